// ===== hdl/kts_pkg.sv =====
package kts_pkg;

    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // interpolation modes
    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_HERMITE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        [DATA_W-1:0] key_time;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] in_slope;
        logic signed [DATA_W-1:0] out_slope;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_SMP_RD0,
        ST_SMP_CHK0,
        ST_SMP_RDL,
        ST_SMP_CHKL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV_INIT,
        ST_DIV,
        ST_MODE,
        ST_LIN,
        ST_H_T2,
        ST_H_T2C,
        ST_H_T3,
        ST_H_T3C,
        ST_H_S3,
        ST_H_S4,
        ST_H_A1,
        ST_H_A2,
        ST_H_A3,
        ST_H_A4,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {RD_ZERO, RD_LAST, RD_IDX, RD_IDX_M1} rd_sel_t;
    typedef enum logic [2:0] {IDX_HOLD, IDX_COUNT, IDX_ONE, IDX_INC, IDX_DEC} idx_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC} cnt_op_t;
    typedef enum logic [3:0] {
        MAC_NONE, MAC_TT, MAC_T2T, MAC_H3DT, MAC_H4DT,
        MAC_H1V1, MAC_H2V2, MAC_S3O, MAC_S4I, MAC_LIN
    } mac_sel_t;
    typedef enum logic [2:0] {CAP_NONE, CAP_T2, CAP_T3, CAP_S3, CAP_S4} cap_sel_t;
    typedef enum logic [2:0] {RES_NONE, RES_ZERO, RES_RD, RES_LO, RES_ACC} res_sel_t;

    typedef struct packed {
        logic       latch_item;
        rd_sel_t    rd_sel;
        logic       wr_en;
        logic       wr_new;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       cap_lo;
        logic       cap_hi;
        logic       div_init;
        logic       div_step;
        mac_sel_t   mac_sel;
        cap_sel_t   cap_sel;
        res_sel_t   res_sel;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic       count_zero;
        logic       count_one;
        logic       count_full;
        logic       smp_le_rd;
        logic       smp_ge_rd;
        logic       rd_le_key;
        logic       idx_is_one;
        logic       div_last;
        logic [1:0] mode;
    } sts_t;

endpackage

// ===== hdl/kts_ram.sv =====
module kts_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/kts_datapath.sv =====
module kts_datapath #(
    parameter int MAX_KEYS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [31:0]                 s_key_time,
    input  logic signed [31:0]          s_key_value,
    input  logic signed [31:0]          s_in_slope,
    input  logic signed [31:0]          s_out_slope,
    input  logic [31:0]                 s_sample_time,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_wdata,
    input  kts_pkg::cmd_t               cmd,
    output kts_pkg::sts_t               sts,
    output logic signed [31:0]          m_sampled_value,
    output logic [1:0]                  m_status
);
    import kts_pkg::*;

    localparam int AW   = $clog2(MAX_KEYS);
    localparam int CW   = $clog2(MAX_KEYS + 1);
    localparam int DCW  = $clog2(FRAC_BITS + 1);
    localparam int WH   = FRAC_BITS + 3;
    localparam int WB   = DATA_W + 1;
    localparam int WA   = WH + WB - FRAC_BITS;
    localparam int WP   = WA + WB;
    localparam int WACC = WP + 2;
    localparam int WSH  = WACC - FRAC_BITS;
    localparam logic signed [WH-1:0] ONE_H = WH'(1) << FRAC_BITS;

    logic [1:0]        mode_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    entry_t            item_reg;
    logic [31:0]       sample_reg;
    entry_t            lo_reg, hi_reg, rd_entry;
    logic [ENTRY_W-1:0] rd_raw, wr_data;
    logic [AW-1:0]     raddr;
    logic [CW-1:0]     count_m1, idx_m1;

    logic [31:0]            dt_reg, rem_reg;
    logic [FRAC_BITS-1:0]   q_reg, t2_reg, t3_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic [32:0]            rem_sh;
    logic                   rem_ge;

    logic signed [WH-1:0]   t_e, t2_e, t3_e, h1, h2, h3, h4;
    logic signed [WA-1:0]   s3_reg, s4_reg, mac_a;
    logic signed [WB-1:0]   mac_b;
    logic signed [WP-1:0]   prod;
    logic signed [WACC-1:0] acc_reg, acc_next, prod_x, base_x;
    logic signed [WSH-1:0]  shifted;
    logic signed [31:0]     sat_val, res_val;
    logic [WSH-32:0]        top_bits;

    assign count_m1 = count_reg - CW'(1);
    assign idx_m1   = idx_reg - CW'(1);
    assign rd_entry = entry_t'(rd_raw);

    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO:   raddr = '0;
            RD_LAST:   raddr = count_m1[AW-1:0];
            RD_IDX:    raddr = idx_reg[AW-1:0];
            RD_IDX_M1: raddr = idx_m1[AW-1:0];
            default:   raddr = '0;
        endcase
    end

    assign wr_data = cmd.wr_new ? ENTRY_W'(item_reg) : rd_raw;

    kts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEYS)) u_ram (
        .clk   (aclk),
        .we    (cmd.wr_en),
        .waddr (idx_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rd_raw)
    );

    always_comb begin
        case (cmd.cnt_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CW'(1);
            default:   count_next = count_reg;
        endcase
        case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg;
            IDX_ONE:   idx_next = CW'(1);
            IDX_INC:   idx_next = idx_reg + CW'(1);
            IDX_DEC:   idx_next = idx_m1;
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LINEAR;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            count_reg <= count_next;
        end
    end

    // restoring division, one quotient bit per cycle; remainder stays below dt
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, dt_reg};

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.latch_item) begin
            item_reg.key_time  <= s_key_time;
            item_reg.value     <= s_key_value;
            item_reg.in_slope  <= s_in_slope;
            item_reg.out_slope <= s_out_slope;
            sample_reg         <= s_sample_time;
        end
        if (cmd.cap_lo) begin
            lo_reg <= rd_entry;
        end
        if (cmd.cap_hi) begin
            hi_reg <= rd_entry;
        end
        if (cmd.div_init) begin
            rem_reg  <= sample_reg - lo_reg.key_time;
            dt_reg   <= hi_reg.key_time - lo_reg.key_time;
            q_reg    <= '0;
            dcnt_reg <= DCW'(FRAC_BITS);
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? rem_sh[31:0] - dt_reg : rem_sh[31:0];
            q_reg    <= {q_reg[FRAC_BITS-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        case (cmd.cap_sel)
            CAP_T2:  t2_reg <= acc_reg[FRAC_BITS +: FRAC_BITS];
            CAP_T3:  t3_reg <= acc_reg[FRAC_BITS +: FRAC_BITS];
            CAP_S3:  s3_reg <= acc_reg[FRAC_BITS +: WA];
            CAP_S4:  s4_reg <= acc_reg[FRAC_BITS +: WA];
            default: ;
        endcase
        acc_reg <= acc_next;
        if (cmd.res_sel != RES_NONE) begin
            m_sampled_value <= res_val;
            m_status        <= cmd.res_status;
        end
    end

    // Hermite basis, all Q.FRAC_BITS
    assign t_e  = $signed({3'b000, q_reg});
    assign t2_e = $signed({3'b000, t2_reg});
    assign t3_e = $signed({3'b000, t3_reg});
    assign h1   = (t3_e <<< 1) - (t2_e + (t2_e <<< 1)) + ONE_H;
    assign h2   = (t2_e + (t2_e <<< 1)) - (t3_e <<< 1);
    assign h3   = t3_e - (t2_e <<< 1) + t_e;
    assign h4   = t3_e - t2_e;

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        case (cmd.mac_sel)
            MAC_TT: begin
                mac_a = $signed({{(WA-FRAC_BITS){1'b0}}, q_reg});
                mac_b = $signed({{(WB-FRAC_BITS){1'b0}}, q_reg});
            end
            MAC_T2T: begin
                mac_a = $signed({{(WA-FRAC_BITS){1'b0}}, t2_reg});
                mac_b = $signed({{(WB-FRAC_BITS){1'b0}}, q_reg});
            end
            MAC_H3DT: begin
                mac_a = {{(WA-WH){h3[WH-1]}}, h3};
                mac_b = $signed({1'b0, dt_reg});
            end
            MAC_H4DT: begin
                mac_a = {{(WA-WH){h4[WH-1]}}, h4};
                mac_b = $signed({1'b0, dt_reg});
            end
            MAC_H1V1: begin
                mac_a = {{(WA-WH){h1[WH-1]}}, h1};
                mac_b = {lo_reg.value[31], lo_reg.value};
            end
            MAC_H2V2: begin
                mac_a = {{(WA-WH){h2[WH-1]}}, h2};
                mac_b = {hi_reg.value[31], hi_reg.value};
            end
            MAC_S3O: begin
                mac_a = s3_reg;
                mac_b = {lo_reg.out_slope[31], lo_reg.out_slope};
            end
            MAC_S4I: begin
                mac_a = s4_reg;
                mac_b = {hi_reg.in_slope[31], hi_reg.in_slope};
            end
            MAC_LIN: begin
                mac_a = {{(WA-33){hi_reg.value[31]}}, hi_reg.value[31], hi_reg.value}
                      - {{(WA-33){lo_reg.value[31]}}, lo_reg.value[31], lo_reg.value};
                mac_b = $signed({{(WB-FRAC_BITS){1'b0}}, q_reg});
            end
            default: ;
        endcase
    end

    assign prod   = mac_a * mac_b;
    assign prod_x = {{(WACC-WP){prod[WP-1]}}, prod};
    assign base_x = {{(WACC-32-FRAC_BITS){lo_reg.value[31]}}, lo_reg.value,
                     {FRAC_BITS{1'b0}}};

    always_comb begin
        case (cmd.mac_sel)
            MAC_TT, MAC_T2T, MAC_H3DT, MAC_H4DT, MAC_H1V1: acc_next = prod_x;
            MAC_H2V2, MAC_S3O, MAC_S4I:                    acc_next = acc_reg + prod_x;
            MAC_LIN:                                       acc_next = base_x + prod_x;
            default:                                       acc_next = acc_reg;
        endcase
    end

    // floor shift then clamp to 32-bit signed
    assign shifted  = acc_reg[WACC-1:FRAC_BITS];
    assign top_bits = shifted[WSH-1:31];
    assign sat_val  = ((&top_bits) || !(|top_bits)) ? shifted[31:0] :
                      (shifted[WSH-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    always_comb begin
        case (cmd.res_sel)
            RES_RD:  res_val = rd_entry.value;
            RES_LO:  res_val = lo_reg.value;
            RES_ACC: res_val = sat_val;
            default: res_val = '0;
        endcase
    end

    assign sts.count_zero = count_reg == '0;
    assign sts.count_one  = count_reg == CW'(1);
    assign sts.count_full = count_reg >= CW'(MAX_KEYS);
    assign sts.smp_le_rd  = sample_reg <= rd_entry.key_time;
    assign sts.smp_ge_rd  = sample_reg >= rd_entry.key_time;
    assign sts.rd_le_key  = rd_entry.key_time <= item_reg.key_time;
    assign sts.idx_is_one = idx_reg == CW'(1);
    assign sts.div_last   = dcnt_reg == DCW'(1);
    assign sts.mode       = mode_reg;

endmodule

// ===== hdl/kts_ctrl.sv =====
module kts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_operation,
    output logic          m_valid,
    input  logic          m_ready,
    input  kts_pkg::sts_t sts,
    output kts_pkg::cmd_t cmd
);
    import kts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_operation)
                        OP_INSERT: begin
                            if (sts.count_full)      state_next = ST_OUT;
                            else if (sts.count_zero) state_next = ST_INS_WR;
                            else                     state_next = ST_INS_RD;
                        end
                        OP_SAMPLE: state_next = sts.count_zero ? ST_OUT : ST_SMP_RD0;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_INS_RD:   state_next = ST_INS_CHK;
            ST_INS_CHK: begin
                if (sts.rd_le_key || sts.idx_is_one) state_next = ST_INS_WR;
                else                                 state_next = ST_INS_RD;
            end
            ST_INS_WR:   state_next = ST_OUT;
            ST_SMP_RD0:  state_next = ST_SMP_CHK0;
            ST_SMP_CHK0: state_next = (sts.count_one || sts.smp_le_rd) ? ST_OUT : ST_SMP_RDL;
            ST_SMP_RDL:  state_next = ST_SMP_CHKL;
            ST_SMP_CHKL: state_next = sts.smp_ge_rd ? ST_OUT : ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = sts.smp_ge_rd ? ST_SCAN_RD : ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      state_next = sts.div_last ? ST_MODE : ST_DIV;
            ST_MODE: begin
                case (sts.mode)
                    MODE_STEP:    state_next = ST_OUT;
                    MODE_HERMITE: state_next = ST_H_T2;
                    default:      state_next = ST_LIN;
                endcase
            end
            ST_LIN:   state_next = ST_FINAL;
            ST_H_T2:  state_next = ST_H_T2C;
            ST_H_T2C: state_next = ST_H_T3;
            ST_H_T3:  state_next = ST_H_T3C;
            ST_H_T3C: state_next = ST_H_S3;
            ST_H_S3:  state_next = ST_H_S4;
            ST_H_S4:  state_next = ST_H_A1;
            ST_H_A1:  state_next = ST_H_A2;
            ST_H_A2:  state_next = ST_H_A3;
            ST_H_A3:  state_next = ST_H_A4;
            ST_H_A4:  state_next = ST_FINAL;
            ST_FINAL: state_next = ST_OUT;
            ST_OUT:   state_next = m_ready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.rd_sel     = RD_ZERO;
        cmd.idx_op     = IDX_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.mac_sel    = MAC_NONE;
        cmd.cap_sel    = CAP_NONE;
        cmd.res_sel    = RES_NONE;
        cmd.res_status = STATUS_OK;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.latch_item = s_valid;
                if (s_valid) begin
                    case (s_operation)
                        OP_CLEAR: begin
                            cmd.cnt_op  = CNT_CLEAR;
                            cmd.res_sel = RES_ZERO;
                        end
                        OP_INSERT: begin
                            cmd.idx_op = IDX_COUNT;
                            if (sts.count_full) begin
                                cmd.res_sel    = RES_ZERO;
                                cmd.res_status = STATUS_FULL;
                            end
                        end
                        OP_SAMPLE: begin
                            if (sts.count_zero) begin
                                cmd.res_sel    = RES_ZERO;
                                cmd.res_status = STATUS_EMPTY;
                            end
                        end
                        default: cmd.res_sel = RES_ZERO;
                    endcase
                end
            end
            ST_INS_RD: cmd.rd_sel = RD_IDX_M1;
            ST_INS_CHK: begin
                // entry above the new key moves up one slot
                if (!sts.rd_le_key) begin
                    cmd.wr_en  = 1'b1;
                    cmd.idx_op = IDX_DEC;
                end
            end
            ST_INS_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.cnt_op  = CNT_INC;
                cmd.res_sel = RES_ZERO;
            end
            ST_SMP_RD0: cmd.rd_sel = RD_ZERO;
            ST_SMP_CHK0: begin
                cmd.cap_lo = 1'b1;
                if (sts.count_one || sts.smp_le_rd) begin
                    cmd.res_sel = RES_RD;
                end
            end
            ST_SMP_RDL: cmd.rd_sel = RD_LAST;
            ST_SMP_CHKL: begin
                if (sts.smp_ge_rd) cmd.res_sel = RES_RD;
                else               cmd.idx_op  = IDX_ONE;
            end
            ST_SCAN_RD: cmd.rd_sel = RD_IDX;
            ST_SCAN_CHK: begin
                if (sts.smp_ge_rd) begin
                    cmd.cap_lo = 1'b1;
                    cmd.idx_op = IDX_INC;
                end else begin
                    cmd.cap_hi = 1'b1;
                end
            end
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_MODE: begin
                if (sts.mode == MODE_STEP) cmd.res_sel = RES_LO;
            end
            ST_LIN:   cmd.mac_sel = MAC_LIN;
            ST_H_T2:  cmd.mac_sel = MAC_TT;
            ST_H_T2C: cmd.cap_sel = CAP_T2;
            ST_H_T3:  cmd.mac_sel = MAC_T2T;
            ST_H_T3C: cmd.cap_sel = CAP_T3;
            ST_H_S3:  cmd.mac_sel = MAC_H3DT;
            ST_H_S4: begin
                cmd.cap_sel = CAP_S3;
                cmd.mac_sel = MAC_H4DT;
            end
            ST_H_A1: begin
                cmd.cap_sel = CAP_S4;
                cmd.mac_sel = MAC_H1V1;
            end
            ST_H_A2:  cmd.mac_sel = MAC_H2V2;
            ST_H_A3:  cmd.mac_sel = MAC_S3O;
            ST_H_A4:  cmd.mac_sel = MAC_S4I;
            ST_FINAL: cmd.res_sel = RES_ACC;
            ST_OUT:   m_valid     = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new item taken while one is in flight");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready && !m_valid)
        else $error("block not idle after result delivered");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && !sts.div_last |=> state_reg == ST_DIV)
        else $error("division left early");
`endif

endmodule

// ===== hdl/keyframe_track_sampler.sv =====
// Channel | Handshake          | Payload
// s_      | s_valid / s_ready  | s_operation, s_key_time, s_key_value, s_in_slope,
//         |                    | s_out_slope, s_sample_time
// m_      | m_valid / m_ready  | m_sampled_value, m_status
// cfg_    | cfg_we (no stall)  | cfg_wdata (interp_mode)
//
// One item at a time; while m_ready is low the result is held in the output state.
// Clear, unknown op, empty-table sample and full-table insert go straight to the result.
// Insert: a read and a check for each entry above the new key, then the new key is written.
// Sample of an n-entry table: clamped at an end after reading the first or last entry, else
// the end reads and scan (one RAM read per entry), the serial divider, the mode decision,
// then the step result directly, or the linear or Hermite steps on the shared MAC and the result.
// aresetn is synchronous; table contents survive reset, the count is cleared.
// m_valid holds until m_ready; s_ready is low until the result is taken.
module keyframe_track_sampler #(
    parameter int MAX_KEYS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [31:0]        s_key_time,
    input  logic signed [31:0] s_key_value,
    input  logic signed [31:0] s_in_slope,
    input  logic signed [31:0] s_out_slope,
    input  logic [31:0]        s_sample_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sampled_value,
    output logic [1:0]         m_status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata
);
    import kts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kts_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    kts_datapath #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_key_time      (s_key_time),
        .s_key_value     (s_key_value),
        .s_in_slope      (s_in_slope),
        .s_out_slope     (s_out_slope),
        .s_sample_time   (s_sample_time),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_sampled_value (m_sampled_value),
        .m_status        (m_status)
    );

endmodule

// ===== bench/keyframe_track_sampler_test.sv =====
`timescale 1ns / 100ps

module keyframe_track_sampler_test;
    import kts_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 2000000;
    // operation code with no effect
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = OP_CLEAR;
    logic [31:0]        s_key_time = '0;
    logic signed [31:0] s_key_value = '0;
    logic signed [31:0] s_in_slope = '0;
    logic signed [31:0] s_out_slope = '0;
    logic [31:0]        s_sample_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_sampled_value;
    logic [1:0]         m_status;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_wdata = MODE_LINEAR;

    keyframe_track_sampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_key_time(s_key_time),
        .s_key_value(s_key_value), .s_in_slope(s_in_slope),
        .s_out_slope(s_out_slope), .s_sample_time(s_sample_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sampled_value(m_sampled_value), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // predictor state
    logic [31:0]        key_times [TABLE_DEPTH];
    logic signed [31:0] key_values [TABLE_DEPTH];
    logic signed [31:0] key_in_slopes [TABLE_DEPTH];
    logic signed [31:0] key_out_slopes [TABLE_DEPTH];
    int                 key_count;
    logic [1:0]         mode_reg;

    logic signed [31:0] want_values [$];
    logic [1:0]         want_status [$];

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_cycles = 0;
    bit     failed = 1'b0;
    longint cycle_count = 0;

    function automatic longint floor_q(longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint interpolate(logic [31:0] s);
        int n, i;
        longint v1, v2, t, t2, t3, h1, h2, h3, h4, s3, s4, acc, dt, one;
        n = key_count;
        i = 0;
        one = longint'(1) << FRAC;
        if (n == 1 || s <= key_times[0]) return key_values[0];
        if (s >= key_times[n-1]) return key_values[n-1];
        for (int k = 0; k + 1 < n; k++) begin
            if (s >= key_times[k] && s < key_times[k+1]) begin
                i = k;
                break;
            end
        end
        dt = longint'({32'd0, key_times[i+1]}) - longint'({32'd0, key_times[i]});
        if (dt == 0) return key_values[i];
        t = ((longint'({32'd0, s}) - longint'({32'd0, key_times[i]})) << FRAC) / dt;
        v1 = key_values[i];
        v2 = key_values[i+1];
        if (mode_reg == MODE_STEP) return v1;
        if (mode_reg == MODE_HERMITE) begin
            t2 = (t * t) >>> FRAC;
            t3 = (t2 * t) >>> FRAC;
            h1 = 2*t3 - 3*t2 + one;
            h2 = 3*t2 - 2*t3;
            h3 = t3 - 2*t2 + t;
            h4 = t3 - t2;
            s3 = floor_q(h3 * dt);
            s4 = floor_q(h4 * dt);
            acc = h1*v1 + h2*v2 + s3*longint'(key_out_slopes[i])
                + s4*longint'(key_in_slopes[i+1]);
            return clip32(floor_q(acc));
        end
        acc = v1*one + (v2 - v1)*t;
        return clip32(floor_q(acc));
    endfunction

    task automatic predict_item(logic [1:0] op, logic [31:0] kt, logic signed [31:0] kv,
                                logic signed [31:0] ki, logic signed [31:0] ko,
                                logic [31:0] st);
        longint value;
        logic [1:0] status;
        int pos;
        value = 0;
        status = STATUS_OK;
        if (op == OP_CLEAR) begin
            key_count = 0;
        end else if (op == OP_INSERT) begin
            if (key_count >= TABLE_DEPTH) begin
                status = STATUS_FULL;
            end else begin
                pos = 0;
                while (pos < key_count && key_times[pos] <= kt) pos++;
                for (int j = key_count; j > pos; j--) begin
                    key_times[j] = key_times[j-1];
                    key_values[j] = key_values[j-1];
                    key_in_slopes[j] = key_in_slopes[j-1];
                    key_out_slopes[j] = key_out_slopes[j-1];
                end
                key_times[pos] = kt;
                key_values[pos] = kv;
                key_in_slopes[pos] = ki;
                key_out_slopes[pos] = ko;
                key_count++;
            end
        end else if (op == OP_SAMPLE) begin
            if (key_count == 0) status = STATUS_EMPTY;
            else value = interpolate(st);
        end
        want_values = {want_values, value[31:0]};
        want_status = {want_status, status};
    endtask

    // valid stays up between items; idle gaps and drain_results take it down
    task automatic send_item(logic [1:0] op, logic [31:0] kt, logic signed [31:0] kv,
                             logic signed [31:0] ki, logic signed [31:0] ko,
                             logic [31:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_key_time <= kt;
        s_key_value <= kv;
        s_in_slope <= ki;
        s_out_slope <= ko;
        s_sample_time <= st;
        predict_item(op, kt, kv, ki, ko, st);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic insert_key(logic [31:0] kt, logic signed [31:0] kv,
                              logic signed [31:0] ki, logic signed [31:0] ko);
        send_item(OP_INSERT, kt, kv, ki, ko, $urandom);
    endtask

    task automatic sample_at(logic [31:0] st);
        send_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, st);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (want_values.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mode_reg = m;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_values.size() == 0) begin
                $display("%0t: unexpected item value %0d status %0d",
                         $realtime, m_sampled_value, m_status);
                failed = 1'b1;
            end else begin
                if (m_sampled_value !== want_values[0]) begin
                    $display("%0t: value expected %0d actual %0d",
                             $realtime, want_values[0], m_sampled_value);
                    failed = 1'b1;
                end
                if (m_status !== want_status[0]) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want_status[0], m_status);
                    failed = 1'b1;
                end
                void'(want_values.pop_front());
                void'(want_status.pop_front());
            end
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keyframe_track_sampler verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        sample_at(32'd0);
        sample_at(32'hFFFF_FFFF);
        insert_key(32'h0001_0000, 32'sh0002_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        sample_at(32'd0);
        sample_at(32'hFFFF_FFFF);
        insert_key(32'h0003_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        insert_key(32'h0003_0000, 32'sh8000_0000, 32'sh0001_0000, 32'sh0000_0000);
        insert_key(32'h0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        insert_key(32'hFFFF_FFFF, 32'sh0000_8000, 32'sh0000_0001, 32'shFFFF_FFFF);
        for (int m = 0; m < 4; m++) begin
            set_mode(m[1:0]);
            sample_at(32'h0001_0000);
            sample_at(32'h0001_8000);
            sample_at(32'h0002_FFFF);
            sample_at(32'h0003_0000);
            sample_at(32'h8000_0000);
        end
        send_item(OP_UNUSED, '1, '1, '1, '1, '1);
        for (int k = 0; k < 28; k++)
            insert_key($urandom, $urandom, $urandom, $urandom);
        sample_at($urandom);
        send_item(OP_CLEAR, '0, '0, '0, '0, '0);
        sample_at(32'd5);
    endtask

    // random content table builds then samples, mixed with random operations
    task automatic test_random(int rounds);
        int nkeys;
        int nsamp;
        logic [31:0] base, span;
        for (int r = 0; r < rounds; r++) begin
            send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            nkeys = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
            base = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0010_0000);
            span = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'h0004_0000;
            for (int k = 0; k < nkeys; k++)
                insert_key(base + $urandom_range(span), $urandom,
                           $urandom_range(1) ? $urandom : $urandom_range(32'h0008_0000),
                           $urandom);
            nsamp = $urandom_range(2, 8);
            for (int k = 0; k < nsamp; k++)
                if ($urandom_range(9) == 0)
                    send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                else
                    sample_at($urandom_range(1) ? $urandom
                                                : base + $urandom_range(span));
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 600;
        for (int k = 0; k < 6; k++) insert_key($urandom, $urandom, $urandom, $urandom);
        for (int k = 0; k < 6; k++) sample_at($urandom);
    endtask

    initial begin
        key_count = 0;
        mode_reg = MODE_LINEAR;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        // phases: no idling, sender idle, receiver stalling, both
        for (int p = 0; p < 4; p++) begin
            set_mode(2'($urandom_range(3)));
            send_idle_pct = (p == 1) ? 78 : (p == 3 ? 18 : 0);
            recv_stall_pct = (p == 2) ? 78 : (p == 3 ? 18 : 0);
            test_random(20);
        end
        set_mode(MODE_HERMITE);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        set_mode(MODE_STEP);
        test_random(10);
        set_mode(MODE_LINEAR);
        test_random(10);
        drain_results();
        if (!failed)
            $display("keyframe_track_sampler verification clean");
        else
            $display("keyframe_track_sampler verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/kts_pkg.sv
hdl/kts_ram.sv
hdl/kts_datapath.sv
hdl/kts_ctrl.sv
hdl/keyframe_track_sampler.sv
bench/keyframe_track_sampler_test.sv
